// ===== hw/rtl/gmvk_pkg.sv =====
// ============================================================================
// gmvk_pkg
// Shared types, constants and helpers of the group membership view keeper.
// ============================================================================
`default_nettype none

package gmvk_pkg;

    // Table sizes and field widths.
    localparam int VIEW_SLOTS    = 64;
    localparam int PENDING_SLOTS = 128;
    localparam int ID_BITS       = 32;
    localparam int POS_FRAC_BITS = 16;
    localparam int POS_BITS      = POS_FRAC_BITS + 1;
    localparam int AGE_BITS      = 16;
    localparam int GRP_BITS      = 16;
    localparam int REPL_BITS     = 11;
    localparam int MAX_GROUPS    = 32768;

    localparam int VIEW_AW  = $clog2(VIEW_SLOTS);
    localparam int PEND_AW  = $clog2(PENDING_SLOTS);
    localparam int VCNT_W   = $clog2(VIEW_SLOTS + 1);
    localparam int PCNT_W   = $clog2(PENDING_SLOTS + 1);
    localparam int PROD_W   = GRP_BITS + POS_BITS;
    localparam int GSUM_W   = PROD_W - POS_FRAC_BITS + 1;

    // Record queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_POS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPL_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPL_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT = 3'd4;

    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    // Input beat.
    typedef struct packed {
        logic                action;
        logic [ID_BITS-1:0]  peer_id;
        logic [POS_BITS-1:0] peer_position;
        logic [AGE_BITS-1:0] peer_age;
        logic [GRP_BITS-1:0] peer_group_count;
        logic                last_record;
    } t_in;

    // Result beat.
    typedef struct packed {
        logic [GRP_BITS-1:0] group_count;
        logic [GRP_BITS-1:0] group_index;
        logic [VCNT_W-1:0]   view_size;
        logic                recovered;
        logic                request_local_view;
        logic                view_overflow;
    } t_out;

    // Classified record as it sits in the queue.
    typedef struct packed {
        logic                is_local;
        logic [ID_BITS-1:0]  id;
        logic [POS_BITS-1:0] pos;
        logic [AGE_BITS-1:0] age;
        logic [GRP_BITS-1:0] pgc;
        logic                last;
    } t_rec;

    // One table entry, view or pending.
    typedef struct packed {
        logic [ID_BITS-1:0]  id;
        logic [POS_BITS-1:0] pos;
        logic [AGE_BITS-1:0] age;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Configuration register file.
    typedef struct packed {
        logic [ID_BITS-1:0]   node_id;
        logic [POS_BITS-1:0]  node_position;
        logic [REPL_BITS-1:0] replication_min;
        logic [REPL_BITS-1:0] replication_max;
        logic [AGE_BITS-1:0]  age_limit;
    } t_cfg;

    // Queue handshake toward the back part.
    typedef struct packed {
        logic valid;
        t_rec rec;
    } t_queue_head;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_AGE_RD,
        ST_AGE_WR,
        ST_GRP,
        ST_MERGE,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_TAIL,
        ST_OWN_MUL,
        ST_OWN_SET,
        ST_CL_RD,
        ST_CL_MUL,
        ST_CL_CHK,
        ST_POST,
        ST_RA_RD,
        ST_RA_MUL,
        ST_RA_CHK,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        KIND_REC_A,
        KIND_REC_B,
        KIND_GOSSIP
    } t_kind;

    // Group of a position from the product groups * position: ceiling,
    // at least one, saturated to the group field.
    function automatic logic [GRP_BITS-1:0] group_of(input logic [PROD_W-1:0] prod);
        logic [PROD_W:0]   s;
        logic [GSUM_W-1:0] g;
        s = {1'b0, prod} + (PROD_W+1)'((1 << POS_FRAC_BITS) - 1);
        g = s[PROD_W:POS_FRAC_BITS];
        if (g == '0) begin
            return GRP_BITS'(1);
        end else if (|g[GSUM_W-1:GRP_BITS]) begin
            return {GRP_BITS{1'b1}};
        end else begin
            return g[GRP_BITS-1:0];
        end
    endfunction

    // Doubling of the group count, saturated at the largest count.
    function automatic logic [GRP_BITS-1:0] doubled(input logic [GRP_BITS-1:0] g);
        logic [GRP_BITS:0] d;
        d = {g, 1'b0};
        if (d > (GRP_BITS+1)'(MAX_GROUPS)) begin
            return GRP_BITS'(MAX_GROUPS);
        end else begin
            return d[GRP_BITS-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gmvk_ram.sv =====
// ============================================================================
// gmvk_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
`default_nettype none

module gmvk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gmvk_front.sv =====
// ============================================================================
// gmvk_front
// Accepts input beats, classifies them and queues them for the back part.
// ============================================================================
`default_nettype none

module gmvk_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire gmvk_pkg::t_in  i_in_data,
    output gmvk_pkg::t_queue_head o_head,
    input  wire logic           i_pop
);

    gmvk_pkg::t_rec                    r_q [gmvk_pkg::QUEUE_DEPTH];
    logic [gmvk_pkg::QUEUE_AW-1:0]     r_wr;
    logic [gmvk_pkg::QUEUE_AW-1:0]     r_rd;
    logic [gmvk_pkg::QCNT_W-1:0]       r_cnt;
    logic                              push;
    logic                              pop;
    gmvk_pkg::t_rec                    rec;

    // Classify: clamp the sender's group count, rename the action.
    always_comb begin
        rec.is_local = i_in_data.action;
        rec.id       = i_in_data.peer_id;
        rec.pos      = i_in_data.peer_position;
        rec.age      = i_in_data.peer_age;
        rec.last     = i_in_data.last_record;
        if (i_in_data.peer_group_count > gmvk_pkg::GRP_BITS'(gmvk_pkg::MAX_GROUPS)) begin
            rec.pgc = gmvk_pkg::GRP_BITS'(gmvk_pkg::MAX_GROUPS);
        end else begin
            rec.pgc = i_in_data.peer_group_count;
        end
    end

    assign o_in_stall   = (r_cnt == gmvk_pkg::QCNT_W'(gmvk_pkg::QUEUE_DEPTH));
    assign push         = i_in_valid && !o_in_stall;
    assign pop          = i_pop && o_head.valid;
    assign o_head.valid = (r_cnt != '0);
    assign o_head.rec   = r_q[r_rd];

    // Queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + gmvk_pkg::QCNT_W'(push) - gmvk_pkg::QCNT_W'(pop);
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= rec;
        end
    end

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.valid)
        else $error("record popped from an empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= gmvk_pkg::QCNT_W'(gmvk_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr == r_rd))
        else $error("empty queue with unequal pointers");

endmodule

`default_nettype wire

// ===== hw/rtl/gmvk_back.sv =====
// ============================================================================
// gmvk_back
// Sequencer that applies queued records to the view and pending tables and
// runs the end-of-message sweeps.
// ============================================================================
`default_nettype none

module gmvk_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire gmvk_pkg::t_cfg        i_cfg,
    input  wire gmvk_pkg::t_queue_head i_head,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output gmvk_pkg::t_out             o_out_data
);

    gmvk_pkg::t_state                  r_state, n_state;
    gmvk_pkg::t_kind                   r_kind, n_kind;
    logic [gmvk_pkg::VIEW_AW-1:0]      r_idx, n_idx;
    logic [gmvk_pkg::PCNT_W-1:0]       r_k, n_k;
    logic [gmvk_pkg::PCNT_W-1:0]       r_pend_cnt, n_pend_cnt;
    logic [gmvk_pkg::VIEW_SLOTS-1:0]   r_valid, n_valid;
    logic [gmvk_pkg::VCNT_W-1:0]       r_cnt, n_cnt;
    logic [gmvk_pkg::GRP_BITS-1:0]     r_groups, n_groups;
    logic [gmvk_pkg::GRP_BITS-1:0]     r_own, n_own;
    logic [gmvk_pkg::GRP_BITS-1:0]     r_pgmax, n_pgmax;
    logic                              r_recov, n_recov;
    logic                              r_mid, n_mid;
    logic                              r_ovf, n_ovf;
    logic                              r_req, n_req;
    logic                              r_readmit, n_readmit;
    logic                              r_free_found, n_free_found;
    logic [gmvk_pkg::VIEW_AW-1:0]      r_free_idx, n_free_idx;
    logic                              r_out_valid, n_out_valid;

    gmvk_pkg::t_rec                    r_rec, n_rec;
    gmvk_pkg::t_entry                  r_ins, n_ins;
    gmvk_pkg::t_entry                  r_ent, n_ent;
    logic [gmvk_pkg::PROD_W-1:0]       r_prod, n_prod;
    gmvk_pkg::t_out                    r_out, n_out;

    logic [gmvk_pkg::POS_BITS-1:0]     mul_pos;
    logic [gmvk_pkg::GRP_BITS-1:0]     grp;
    logic [gmvk_pkg::REPL_BITS-1:0]    est;
    logic [gmvk_pkg::GRP_BITS-1:0]     g_half;

    logic                              v_we;
    logic [gmvk_pkg::VIEW_AW-1:0]      v_waddr;
    gmvk_pkg::t_entry                  v_wdata;
    logic [gmvk_pkg::ENTRY_W-1:0]      v_rdata;
    gmvk_pkg::t_entry                  v_ent;
    logic                              p_we;
    logic [gmvk_pkg::PEND_AW-1:0]      p_waddr;
    gmvk_pkg::t_entry                  p_wdata;
    logic [gmvk_pkg::ENTRY_W-1:0]      p_rdata;
    gmvk_pkg::t_entry                  p_ent;

    assign v_ent = v_rdata;
    assign p_ent = p_rdata;

    // View table: id, position and age of each slot.
    gmvk_ram #(
        .WIDTH (gmvk_pkg::ENTRY_W),
        .DEPTH (gmvk_pkg::VIEW_SLOTS)
    ) u_view_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_raddr (r_idx),
        .o_rdata (v_rdata)
    );

    // Pending table: peers set aside during a gossip message.
    gmvk_ram #(
        .WIDTH (gmvk_pkg::ENTRY_W),
        .DEPTH (gmvk_pkg::PENDING_SLOTS)
    ) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (r_k[gmvk_pkg::PEND_AW-1:0]),
        .o_rdata (p_rdata)
    );

    // The shared group multiplier; its product is registered.
    assign n_prod = gmvk_pkg::PROD_W'(r_groups) * gmvk_pkg::PROD_W'(mul_pos);
    assign grp    = gmvk_pkg::group_of(r_prod);
    assign est    = gmvk_pkg::REPL_BITS'(r_cnt) + gmvk_pkg::REPL_BITS'(1);
    assign g_half = ((est < i_cfg.replication_min) && (r_groups > gmvk_pkg::GRP_BITS'(1)))
                    ? (r_groups >> 1) : r_groups;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Next state and table control.
    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_idx        = r_idx;
        n_k          = r_k;
        n_pend_cnt   = r_pend_cnt;
        n_valid      = r_valid;
        n_cnt        = r_cnt;
        n_groups     = r_groups;
        n_own        = r_own;
        n_pgmax      = r_pgmax;
        n_recov      = r_recov;
        n_mid        = r_mid;
        n_ovf        = r_ovf;
        n_req        = r_req;
        n_readmit    = r_readmit;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_out_valid  = r_out_valid && i_out_stall;
        n_rec        = r_rec;
        n_ins        = r_ins;
        n_ent        = r_ent;
        n_out        = r_out;
        mul_pos      = r_rec.pos;
        o_pop        = 1'b0;
        v_we         = 1'b0;
        v_waddr      = r_idx;
        v_wdata      = v_ent;
        p_we         = 1'b0;
        p_waddr      = r_pend_cnt[gmvk_pkg::PEND_AW-1:0];
        p_wdata      = r_ins;

        unique case (r_state)
            // Take a record; a new message clears the per-message state.
            gmvk_pkg::ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop     = 1'b1;
                    n_rec     = i_head.rec;
                    n_ins.id  = i_head.rec.id;
                    n_ins.pos = i_head.rec.pos;
                    n_ins.age = i_head.rec.age;
                    n_mid     = !i_head.rec.last;
                    n_idx     = '0;
                    if (!r_mid) begin
                        n_pend_cnt = '0;
                        n_ovf      = 1'b0;
                        n_pgmax    = gmvk_pkg::GRP_BITS'(1);
                    end
                    if (r_recov &&
                        (i_head.rec.pgc > (r_mid ? r_pgmax : gmvk_pkg::GRP_BITS'(1)))) begin
                        n_pgmax = i_head.rec.pgc;
                    end
                    if (!r_mid && !i_head.rec.is_local && !r_recov) begin
                        n_state = gmvk_pkg::ST_AGE_RD;
                    end else begin
                        n_state = gmvk_pkg::ST_GRP;
                    end
                end
            end

            // Ageing sweep over the view.
            gmvk_pkg::ST_AGE_RD: begin
                n_state = gmvk_pkg::ST_AGE_WR;
            end
            gmvk_pkg::ST_AGE_WR: begin
                if (r_valid[r_idx] && (v_ent.age != gmvk_pkg::AGE_MAX)) begin
                    v_we        = 1'b1;
                    v_wdata.age = v_ent.age + 1'b1;
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == gmvk_pkg::VIEW_AW'(gmvk_pkg::VIEW_SLOTS - 1)) begin
                    n_state = gmvk_pkg::ST_GRP;
                end else begin
                    n_state = gmvk_pkg::ST_AGE_RD;
                end
            end

            gmvk_pkg::ST_GRP: begin
                n_state = gmvk_pkg::ST_MERGE;
            end

            // Decide between a view search, a pending push or nothing.
            gmvk_pkg::ST_MERGE: begin
                n_readmit = 1'b0;
                if ((grp == r_own) && (r_rec.id != i_cfg.node_id)) begin
                    n_idx        = '0;
                    n_free_found = 1'b0;
                    n_state      = gmvk_pkg::ST_FIND_RD;
                end else begin
                    if (!r_recov && !r_rec.is_local) begin
                        if (r_pend_cnt >= gmvk_pkg::PCNT_W'(gmvk_pkg::PENDING_SLOTS)) begin
                            n_ovf = 1'b1;
                        end else begin
                            p_we       = 1'b1;
                            n_pend_cnt = r_pend_cnt + 1'b1;
                        end
                    end
                    n_state = gmvk_pkg::ST_TAIL;
                end
            end

            // View search by id, noting the lowest free slot on the way.
            gmvk_pkg::ST_FIND_RD: begin
                n_state = gmvk_pkg::ST_FIND_CHK;
            end
            gmvk_pkg::ST_FIND_CHK: begin
                if (r_valid[r_idx] && (v_ent.id == r_ins.id)) begin
                    if (!r_readmit && (v_ent.age > r_ins.age)) begin
                        v_we        = 1'b1;
                        v_wdata.age = r_ins.age;
                        if (!r_recov && !r_rec.is_local) begin
                            v_wdata.pos = r_ins.pos;
                        end
                    end
                    if (r_readmit) begin
                        n_readmit = 1'b0;
                        n_k       = r_k + 1'b1;
                        n_state   = gmvk_pkg::ST_RA_RD;
                    end else begin
                        n_state = gmvk_pkg::ST_TAIL;
                    end
                end else begin
                    if (!r_valid[r_idx] && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_idx;
                    end
                    n_idx = r_idx + 1'b1;
                    if (r_idx == gmvk_pkg::VIEW_AW'(gmvk_pkg::VIEW_SLOTS - 1)) begin
                        // Not found: insert at the lowest free slot.
                        if (r_free_found || !r_valid[r_idx]) begin
                            v_we    = 1'b1;
                            v_waddr = r_free_found ? r_free_idx : r_idx;
                            v_wdata = r_ins;
                            n_valid[v_waddr] = 1'b1;
                            n_cnt   = r_cnt + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                        if (r_readmit) begin
                            n_readmit = 1'b0;
                            n_k       = r_k + 1'b1;
                            n_state   = gmvk_pkg::ST_RA_RD;
                        end else begin
                            n_state = gmvk_pkg::ST_TAIL;
                        end
                    end else begin
                        n_state = gmvk_pkg::ST_FIND_RD;
                    end
                end
            end

            // End of record; on the last one pick the end-of-message path.
            gmvk_pkg::ST_TAIL: begin
                n_idx = '0;
                if (!r_rec.last) begin
                    n_state = gmvk_pkg::ST_IDLE;
                end else begin
                    n_req = 1'b0;
                    if (r_recov) begin
                        if ((r_groups > r_pgmax) && (est >= i_cfg.replication_min)) begin
                            if (est > i_cfg.replication_max) begin
                                n_groups = gmvk_pkg::doubled(r_groups);
                                n_kind   = gmvk_pkg::KIND_REC_A;
                                n_state  = gmvk_pkg::ST_OWN_MUL;
                            end else begin
                                n_recov = 1'b0;
                                n_state = gmvk_pkg::ST_OUT;
                            end
                        end else begin
                            n_groups = r_pgmax;
                            n_kind   = gmvk_pkg::KIND_REC_B;
                            n_state  = gmvk_pkg::ST_OWN_MUL;
                        end
                    end else if (!r_rec.is_local) begin
                        n_kind  = gmvk_pkg::KIND_GOSSIP;
                        n_state = gmvk_pkg::ST_CL_RD;
                    end else begin
                        n_state = gmvk_pkg::ST_OUT;
                    end
                end
            end

            // Own group from the node position.
            gmvk_pkg::ST_OWN_MUL: begin
                mul_pos = i_cfg.node_position;
                n_state = gmvk_pkg::ST_OWN_SET;
            end
            gmvk_pkg::ST_OWN_SET: begin
                n_own = grp;
                n_idx = '0;
                n_k   = '0;
                if (r_kind == gmvk_pkg::KIND_GOSSIP) begin
                    n_state = gmvk_pkg::ST_RA_RD;
                end else begin
                    n_state = gmvk_pkg::ST_CL_RD;
                end
            end

            // Cleaning sweep: evict other-group and over-age entries.
            gmvk_pkg::ST_CL_RD: begin
                n_state = gmvk_pkg::ST_CL_MUL;
            end
            gmvk_pkg::ST_CL_MUL: begin
                mul_pos = v_ent.pos;
                n_ent   = v_ent;
                n_state = gmvk_pkg::ST_CL_CHK;
            end
            gmvk_pkg::ST_CL_CHK: begin
                if (r_valid[r_idx]) begin
                    if (grp != r_own) begin
                        if (r_kind == gmvk_pkg::KIND_GOSSIP) begin
                            p_wdata = r_ent;
                            if (r_pend_cnt >= gmvk_pkg::PCNT_W'(gmvk_pkg::PENDING_SLOTS)) begin
                                n_ovf = 1'b1;
                            end else begin
                                p_we       = 1'b1;
                                n_pend_cnt = r_pend_cnt + 1'b1;
                            end
                        end
                        n_valid[r_idx] = 1'b0;
                        n_cnt          = r_cnt - 1'b1;
                    end else if (r_ent.age > i_cfg.age_limit) begin
                        n_valid[r_idx] = 1'b0;
                        n_cnt          = r_cnt - 1'b1;
                    end
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == gmvk_pkg::VIEW_AW'(gmvk_pkg::VIEW_SLOTS - 1)) begin
                    n_state = gmvk_pkg::ST_POST;
                end else begin
                    n_state = gmvk_pkg::ST_CL_RD;
                end
            end

            // After cleaning: resize the group count or settle recovery.
            gmvk_pkg::ST_POST: begin
                unique case (r_kind)
                    gmvk_pkg::KIND_GOSSIP: begin
                        if (est > i_cfg.replication_max) begin
                            n_groups = gmvk_pkg::doubled(g_half);
                        end else begin
                            n_groups = g_half;
                        end
                        n_state = gmvk_pkg::ST_OWN_MUL;
                    end
                    gmvk_pkg::KIND_REC_A: begin
                        n_recov = 1'b0;
                        n_state = gmvk_pkg::ST_OUT;
                    end
                    gmvk_pkg::KIND_REC_B: begin
                        if ((r_pgmax == gmvk_pkg::GRP_BITS'(1)) ||
                            ((est >= i_cfg.replication_min) &&
                             (est <= i_cfg.replication_max))) begin
                            n_recov = 1'b0;
                        end else begin
                            n_req = 1'b1;
                        end
                        n_state = gmvk_pkg::ST_OUT;
                    end
                    default: begin
                        n_state = gmvk_pkg::ST_OUT;
                    end
                endcase
            end

            // Re-admission sweep over the pending table.
            gmvk_pkg::ST_RA_RD: begin
                if (r_k == r_pend_cnt) begin
                    n_pend_cnt = '0;
                    n_state    = gmvk_pkg::ST_OUT;
                end else begin
                    n_state = gmvk_pkg::ST_RA_MUL;
                end
            end
            gmvk_pkg::ST_RA_MUL: begin
                mul_pos = p_ent.pos;
                n_ins   = p_ent;
                n_state = gmvk_pkg::ST_RA_CHK;
            end
            gmvk_pkg::ST_RA_CHK: begin
                if ((grp == r_own) && (r_ins.id != i_cfg.node_id)) begin
                    n_idx        = '0;
                    n_free_found = 1'b0;
                    n_readmit    = 1'b1;
                    n_state      = gmvk_pkg::ST_FIND_RD;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = gmvk_pkg::ST_RA_RD;
                end
            end

            // Hand the result to the output register once it is free.
            gmvk_pkg::ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid              = 1'b1;
                    n_out.group_count        = r_groups;
                    n_out.group_index        = r_own;
                    n_out.view_size          = r_cnt;
                    n_out.recovered          = !r_recov;
                    n_out.request_local_view = r_req;
                    n_out.view_overflow      = r_ovf;
                    n_state                  = gmvk_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = gmvk_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= gmvk_pkg::ST_IDLE;
            r_kind       <= gmvk_pkg::KIND_GOSSIP;
            r_idx        <= '0;
            r_k          <= '0;
            r_pend_cnt   <= '0;
            r_valid      <= '0;
            r_cnt        <= '0;
            r_groups     <= gmvk_pkg::GRP_BITS'(1);
            r_own        <= gmvk_pkg::GRP_BITS'(1);
            r_pgmax      <= gmvk_pkg::GRP_BITS'(1);
            r_recov      <= 1'b1;
            r_mid        <= 1'b0;
            r_ovf        <= 1'b0;
            r_req        <= 1'b0;
            r_readmit    <= 1'b0;
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_kind       <= n_kind;
            r_idx        <= n_idx;
            r_k          <= n_k;
            r_pend_cnt   <= n_pend_cnt;
            r_valid      <= n_valid;
            r_cnt        <= n_cnt;
            r_groups     <= n_groups;
            r_own        <= n_own;
            r_pgmax      <= n_pgmax;
            r_recov      <= n_recov;
            r_mid        <= n_mid;
            r_ovf        <= n_ovf;
            r_req        <= n_req;
            r_readmit    <= n_readmit;
            r_free_found <= n_free_found;
            r_free_idx   <= n_free_idx;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rec  <= n_rec;
        r_ins  <= n_ins;
        r_ent  <= n_ent;
        r_prod <= n_prod;
        r_out  <= n_out;
    end

    a_cnt_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_cnt))
        else $error("view count differs from valid bits");
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_cnt <= gmvk_pkg::PCNT_W'(gmvk_pkg::PENDING_SLOTS))
        else $error("pending count above table size");
    a_groups_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_groups != '0) && (r_groups <= gmvk_pkg::GRP_BITS'(gmvk_pkg::MAX_GROUPS)))
        else $error("group count out of range");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == gmvk_pkg::ST_IDLE))
        else $error("record taken while busy");

endmodule

`default_nettype wire

// ===== hw/rtl/group_membership_view_keeper.sv =====
// ============================================================================
// group_membership_view_keeper
// Keeps a node's group-local membership view and the group count.
// ============================================================================
// Usage:
// Input beats carry one peer record each; a message is a run of beats whose
// last one has last_record set. Only that last beat yields a result beat,
// carrying group count, own group, view size and status flags.
// A four-deep record queue sits behind the input, so the sender is stalled
// only when it is full. The back sequencer works on one record at a time.
// A record in this node's group adds an id search over the view slots, and
// the first beat of a gossip message outside recovery adds an ageing sweep.
// A gossip message's last beat adds a cleaning sweep over the view and a
// pass over the pending peers, with an id search for each one in this
// node's group. The pace of these sweeps is set by the single read port of
// the view table. A result waits in an output register while the receiver
// stalls; the sequencer goes on with the next record until it has a further
// result to deliver. Reset empties the view and enters recovery with one
// group. Configuration writes are always ready and take effect at once.
// ============================================================================
`default_nettype none

module group_membership_view_keeper (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire gmvk_pkg::t_in                     i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output gmvk_pkg::t_out                         o_out_data,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [gmvk_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [gmvk_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    gmvk_pkg::t_cfg        r_cfg;
    gmvk_pkg::t_queue_head head;
    logic                  pop;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_id         <= '0;
            r_cfg.node_position   <= '0;
            r_cfg.replication_min <= gmvk_pkg::REPL_BITS'(1);
            r_cfg.replication_max <= gmvk_pkg::REPL_BITS'(1);
            r_cfg.age_limit       <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                gmvk_pkg::CFG_NODE_ID: begin
                    r_cfg.node_id <= i_cfg_data[gmvk_pkg::ID_BITS-1:0];
                end
                gmvk_pkg::CFG_NODE_POS: begin
                    r_cfg.node_position <= i_cfg_data[gmvk_pkg::POS_BITS-1:0];
                end
                gmvk_pkg::CFG_REPL_MIN: begin
                    r_cfg.replication_min <= i_cfg_data[gmvk_pkg::REPL_BITS-1:0];
                end
                gmvk_pkg::CFG_REPL_MAX: begin
                    r_cfg.replication_max <= i_cfg_data[gmvk_pkg::REPL_BITS-1:0];
                end
                gmvk_pkg::CFG_AGE_LIMIT: begin
                    r_cfg.age_limit <= i_cfg_data[gmvk_pkg::AGE_BITS-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    gmvk_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_head     (head),
        .i_pop      (pop)
    );

    gmvk_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
